>>> sv/spg_pkg.sv
// Shared constants and types for the sector test pattern generator and checker.
package spg_pkg;

    // Sector geometry. The sector size must stay a power of two.
    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_BITS  = $clog2(SECTOR_BYTES);
    localparam int HEADER_BYTES = 8;
    localparam int HEADER_BITS  = $clog2(HEADER_BYTES);

    // Default width of the running byte address.
    localparam int ADDRESS_BITS_DEF = 48;

    // Field widths on the ports.
    localparam int BYTE_W   = 8;
    localparam int OUTADR_W = 48;
    localparam int COUNT_W  = 32;
    localparam int OFFSET_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = OFFSET_W;

    // Output tdata layout, packed from bit 0 upward and padded to whole bytes.
    localparam int OUT_FIELDS_W = BYTE_W + OUTADR_W + 1 + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'd1;

    // Input opcodes.
    localparam logic OP_NEXT    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Position information for the byte at the current address.
    typedef struct packed {
        logic              in_header;
        logic              first_hdr;
        logic              last_hdr;
        logic [BYTE_W-1:0] exp_byte;
    } t_pos_info;

endpackage

>>> sv/sector_pattern_generate_verify.sv
// Sector test pattern engine: one byte per transaction, address-stamped headers, verify count.
// The block takes one input transaction per clock unless its output stalls, and returns exactly
// one result transaction for each in the cycle after acceptance, via a single output register.
// Input is accepted whenever that register is empty or being taken in the same cycle,
// so with a ready sink the sustained rate is one byte per clock. Each 512-byte sector
// starts with its 8-byte start address, least significant byte first; every other byte
// is the low byte of its own address. In verify mode the read-back header bytes are
// compared and a differing header is flagged on its last byte and counted in a
// saturating 32-bit counter. A restart transaction jumps to the sector-aligned start
// offset and clears the count; writing the start offset alone does not move the address.
module sector_pattern_generate_verify #(
    parameter int ADDRESS_BITS = spg_pkg::ADDRESS_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_wen,
    input  logic [spg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [spg_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] read_byte
    input  logic                               s_axis_tuser,  // [0] opcode
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] pattern_byte, [55:8] byte_address, [56] sector_mismatch,
    // [88:57] error_total, [95:89] zero
    output logic [spg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import spg_pkg::*;

    // Configuration registers.
    logic                  r_verify;
    logic [OFFSET_W-1:0]   r_start;

    // Engine state.
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic                    r_hdiff, n_hdiff;
    logic [COUNT_W-1:0]      r_count, n_count;

    // Output register.
    logic                  r_m_valid;
    logic [BYTE_W-1:0]     r_o_byte, n_o_byte;
    logic [OUTADR_W-1:0]   r_o_addr, n_o_addr;
    logic                  r_o_flag, n_o_flag;

    logic                    accept;
    logic [63:0]             start64;
    logic [ADDRESS_BITS-1:0] aligned;
    logic [63:0]             addr64;
    logic                    diff;
    logic                    hd_acc;
    t_pos_info               info;

    // A new transaction enters when the output register is free or drains now.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Sector-aligned restart address.
    assign start64 = 64'(r_start);
    assign aligned = {start64[ADDRESS_BITS-1:SECTOR_BITS], SECTOR_BITS'(0)};
    assign addr64  = 64'(r_addr);

    spg_pattern #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_pattern (
        .i_addr(r_addr),
        .o_info(info)
    );

    // Next state and result for the accepted transaction.
    always_comb begin
        n_addr   = r_addr;
        n_hdiff  = r_hdiff;
        n_count  = r_count;
        n_o_byte = r_o_byte;
        n_o_addr = r_o_addr;
        n_o_flag = r_o_flag;
        diff     = (s_axis_tdata != info.exp_byte);
        hd_acc   = info.first_hdr ? diff : (r_hdiff || diff);
        if (accept) begin
            if (s_axis_tuser == OP_RESTART) begin
                n_addr   = aligned;
                n_hdiff  = 1'b0;
                n_count  = '0;
                n_o_byte = '0;
                n_o_addr = OUTADR_W'(64'(aligned));
                n_o_flag = 1'b0;
            end else begin
                n_o_byte = info.exp_byte;
                n_o_addr = addr64[OUTADR_W-1:0];
                n_o_flag = 1'b0;
                n_addr   = r_addr + ADDRESS_BITS'(1);
                if (!r_verify) begin
                    n_hdiff = 1'b0;
                end else if (info.in_header) begin
                    n_hdiff = hd_acc;
                    if (info.last_hdr) begin
                        n_hdiff = 1'b0;
                        if (hd_acc) begin
                            n_o_flag = 1'b1;
                            if (r_count != '1) begin
                                n_count = r_count + COUNT_W'(1);
                            end
                        end
                    end
                end
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verify  <= 1'b0;
            r_start   <= '0;
            r_addr    <= '0;
            r_hdiff   <= 1'b0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                unique case (i_cfg_idx)
                    CFG_VERIFY_MODE:  r_verify <= i_cfg_wdata[0];
                    CFG_START_OFFSET: r_start  <= i_cfg_wdata[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            r_addr  <= n_addr;
            r_hdiff <= n_hdiff;
            r_count <= n_count;
            if (accept) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_o_byte <= n_o_byte;
        r_o_addr <= n_o_addr;
        r_o_flag <= n_o_flag;
    end

    logic [COUNT_W-1:0] r_o_count;

    // The error total shown with each result is the count after that transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_o_count <= n_count;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_o_count, r_o_flag, r_o_addr, r_o_byte});

endmodule

>>> sv/spg_pattern.sv
// Expected pattern byte and header position for one byte address.
module spg_pattern #(
    parameter int ADDRESS_BITS = spg_pkg::ADDRESS_BITS_DEF
) (
    input  logic [ADDRESS_BITS-1:0] i_addr,
    output spg_pkg::t_pos_info      o_info
);
    import spg_pkg::*;

    logic [SECTOR_BITS-1:0]  pos;
    logic [HEADER_BITS-1:0]  hdr_idx;
    logic [ADDRESS_BITS-1:0] base;
    logic [63:0]             base64;
    logic                    in_hdr;

    // Position inside the sector and the sector's start address.
    assign pos     = i_addr[SECTOR_BITS-1:0];
    assign hdr_idx = pos[HEADER_BITS-1:0];
    assign in_hdr  = (pos < SECTOR_BITS'(HEADER_BYTES));
    assign base    = {i_addr[ADDRESS_BITS-1:SECTOR_BITS], SECTOR_BITS'(0)};
    assign base64  = 64'(base);

    // Header bytes carry the sector start little-endian; others the address low byte.
    always_comb begin
        o_info.in_header = in_hdr;
        o_info.first_hdr = (pos == '0);
        o_info.last_hdr  = (pos == SECTOR_BITS'(HEADER_BYTES - 1));
        if (in_hdr) begin
            o_info.exp_byte = base64[{hdr_idx, 3'b000} +: BYTE_W];
        end else begin
            o_info.exp_byte = i_addr[BYTE_W-1:0];
        end
    end

endmodule
